// File: src/motor_command_response_model_defines.svh
// ----------------------------------------------------------------------------
// Motor command response model assertion macros
// Shared property forms used by the checker of the motor command block.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_RESPONSE_MODEL_DEFINES_SVH
`define MOTOR_COMMAND_RESPONSE_MODEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mcrm_pkg.sv
// ----------------------------------------------------------------------------
// Motor command response model package
// Widths, codes, reset values and the rounding helper of the block.
// ----------------------------------------------------------------------------
package mcrm_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int RPM_W       = 24;
   localparam int ERR_W       = 25;
   localparam int LIM_W       = 23;
   localparam int CAP_W       = 17;
   localparam int TIME_W      = 32;
   localparam int SRC_W       = 2;
   localparam int DIR_W       = 2;
   localparam int FLAG_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 208;
   localparam int RSP_DATA_W  = 248;

   localparam int MUL_A_W     = 25;
   localparam int MUL_B_W     = 18;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int STEP_W      = PROD_W - FRAC_BITS;

   localparam int DIV_STEPS   = CAP_W;
   localparam int CNT_W       = 5;

   localparam logic [CAP_W-1:0]        FRAC_ONE = 17'h10000;
   localparam logic signed [RPM_W-1:0] RPM_MAX  = 24'sh7FFFFF;
   localparam logic signed [RPM_W-1:0] RPM_MIN  = 24'sh800000;

   localparam logic [TIME_W-1:0] RESET_DEFAULT_TIMEOUT = 32'd500;
   localparam logic [TIME_W-1:0] RESET_MIN_TIMEOUT     = 32'd0;
   localparam logic [TIME_W-1:0] RESET_MAX_TIMEOUT     = 32'd0;
   localparam logic [LIM_W-1:0]  RESET_RPM_LIMIT       = 23'd256000;
   localparam logic [CAP_W-1:0]  RESET_PWM_CEILING     = 17'd65536;
   localparam logic [CAP_W-1:0]  RESET_DEFAULT_CAP     = 17'd65536;
   localparam logic [CAP_W-1:0]  RESET_LAG_ALPHA       = 17'd6554;
   localparam logic [LIM_W-1:0]  RESET_ZERO_SNAP       = 23'd128;

   localparam int FLAG_ENABLED   = 0;
   localparam int FLAG_CONTROL   = 1;
   localparam int FLAG_CLOSED    = 2;
   localparam int FLAG_TIMEOUT   = 3;
   localparam int FLAG_LEGACY    = 4;
   localparam int FLAG_SATURATED = 5;
   localparam int FLAG_ESTOP     = 6;
   localparam int FLAG_FAULT     = 7;

   typedef enum logic [SRC_W-1:0] {
      SRC_NONE,
      SRC_TARGET,
      SRC_MOTOR,
      SRC_LEGACY
   } src_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEFAULT_TIMEOUT,
      REG_MIN_TIMEOUT,
      REG_MAX_TIMEOUT,
      REG_RPM_LIMIT,
      REG_PWM_CEILING,
      REG_DEFAULT_CAP,
      REG_LAG_ALPHA,
      REG_ZERO_SNAP
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMITS,
      ST_CLAMP,
      ST_EVAL,
      ST_DIV,
      ST_MUL_EFF,
      ST_ROUND,
      ST_DIFF,
      ST_MUL_LAG,
      ST_DONE
   } state_type;

   // Shift right by the fraction width, rounding half toward plus infinity.
   function automatic logic signed [STEP_W-1:0] rnd16(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] y;
      y = x + PROD_W'(32768);
      return $signed(y[PROD_W-1:FRAC_BITS]);
   endfunction

endpackage

// File: src/motor_command_response_model.sv
// ----------------------------------------------------------------------------
// Motor command response model
// Takes one control tick with a command snapshot per req transaction and
// returns one rsp transaction with the clamped target, duty, PWM cap,
// effective timeout, status flags and the updated modelled rpm.
// The csr channel writes the eight tuning registers and is always ready;
// it must be written only while the block is idle; the block does not enforce this.
// A tick is accepted when req_tvalid and req_tready are high. It then runs
// through the limit, clamp, eval, divide, multiply, round, diff and lag
// steps before rsp_tvalid rises; no new tick is taken until its result is
// loaded. The 17-step restoring duty divider is the longest step; one shared
// multiplier serves the target scaling and the lag update.
// When the receiver stalls, the finished result waits in the output register
// while the next tick is already taken and worked on; that tick holds in its
// final step until the register is free.
// Reset loads the register defaults, clears the modelled rpm and empties
// the output register.
// ----------------------------------------------------------------------------
module motor_command_response_model (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cmd_enable, cmd_closed_loop, cmd_stop, cmd_target, cmd_pwm_cap,
   // cmd_timeout_ms, cmd_time_ms, cmd_seq, tick_time_ms, tick_count
   input  logic [mcrm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd_source
   input  logic [mcrm_pkg::SRC_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // target_out, model_rpm, rpm_error, duty, pwm_cap_out, timeout_out_ms,
   // direction, status_flags, seq_echo, count_echo, time_echo
   output logic [mcrm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // active_src
   output logic [mcrm_pkg::SRC_W-1:0]         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mcrm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mcrm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mcrm_pkg::*;

   logic [TIME_W-1:0] cfg_def_to_ff, cfg_min_to_ff, cfg_max_to_ff;
   logic [LIM_W-1:0]  cfg_limit_ff, cfg_snap_ff;
   logic [CAP_W-1:0]  cfg_ceil_ff, cfg_defcap_ff, cfg_alpha_ff;

   state_type state_ff, state_in;
   logic      load_rsp;
   logic      rsp_valid_ff;

   src_type                  src_ff;
   logic                     en_ff, cl_ff, st_ff;
   logic signed [RPM_W-1:0]  tgt_in_ff;
   logic [CAP_W-1:0]         ccap_ff;
   logic [TIME_W-1:0]        cto_ff, ctime_ff, seq_ff, now_ff, count_ff;

   logic [TIME_W-1:0]        lo_ff, hi_ff, age_ff, to_ff;
   logic                     tmo_ff, enabled_ff, closed_ff, stop_ff, ctrl_ff, clamped_ff;
   logic signed [RPM_W-1:0]  tgt_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [RPM_W-1:0]         rem_ff;
   logic [CAP_W-1:0]         quo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [RPM_W-1:0]  eff_ff;
   logic signed [ERR_W-1:0]  diff_ff;
   logic signed [RPM_W-1:0]  m_ff;

   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;
   logic [SRC_W-1:0]         rsp_tuser_ff;

   logic [TIME_W-1:0]        lo_w, to_sel;
   logic                     has_w, tmo_w, enabled_w, closed_w, stop_w, ctrl_w;
   logic                     over_w, under_w;
   logic signed [ERR_W-1:0]  tgt_ext, lim_s, neg_lim;
   logic signed [RPM_W-1:0]  tgt_clip, tgt_w, tgt_neg;
   logic [LIM_W-1:0]         tgt_abs;
   logic [CAP_W-1:0]         alpha_w, ceil_w, dcap_w, mcap_w, mcap_lim, cap_w;
   logic                     div_ge;
   logic [RPM_W-1:0]         div_rem;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [STEP_W-1:0] rnd_w, m_sum;
   logic signed [RPM_W-1:0]  m_clip, m_neg, m_new;
   logic [RPM_W-1:0]         m_abs;
   logic [CAP_W-1:0]         rduty_w, duty_w;
   logic                     sat_w;
   logic [DIR_W-1:0]         dir_w;
   logic [FLAG_W-1:0]        flags_w;
   logic signed [ERR_W-1:0]  err_w;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_def_to_ff <= RESET_DEFAULT_TIMEOUT;
         cfg_min_to_ff <= RESET_MIN_TIMEOUT;
         cfg_max_to_ff <= RESET_MAX_TIMEOUT;
         cfg_limit_ff  <= RESET_RPM_LIMIT;
         cfg_ceil_ff   <= RESET_PWM_CEILING;
         cfg_defcap_ff <= RESET_DEFAULT_CAP;
         cfg_alpha_ff  <= RESET_LAG_ALPHA;
         cfg_snap_ff   <= RESET_ZERO_SNAP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_DEFAULT_TIMEOUT: cfg_def_to_ff <= csr_data;
            REG_MIN_TIMEOUT:     cfg_min_to_ff <= csr_data;
            REG_MAX_TIMEOUT:     cfg_max_to_ff <= csr_data;
            REG_RPM_LIMIT:       cfg_limit_ff  <= csr_data[LIM_W-1:0];
            REG_PWM_CEILING:     cfg_ceil_ff   <= csr_data[CAP_W-1:0];
            REG_DEFAULT_CAP:     cfg_defcap_ff <= csr_data[CAP_W-1:0];
            REG_LAG_ALPHA:       cfg_alpha_ff  <= csr_data[CAP_W-1:0];
            REG_ZERO_SNAP:       cfg_snap_ff   <= csr_data[LIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LIMITS;
            end
         end
         ST_LIMITS:  state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_EVAL;
         ST_EVAL:    state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_EFF;
            end
         end
         ST_MUL_EFF: state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_MUL_LAG;
         ST_MUL_LAG: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lo_w   = (cfg_min_to_ff != '0) ? cfg_min_to_ff : cfg_def_to_ff;
      to_sel = (src_ff == SRC_MOTOR && cto_ff != '0) ? cto_ff : cfg_def_to_ff;

      has_w     = (src_ff != SRC_NONE) && (ctime_ff != '0);
      tmo_w     = !has_w || (age_ff > to_ff);
      enabled_w = !tmo_w && (src_ff == SRC_TARGET || (src_ff == SRC_MOTOR && en_ff));
      closed_w  = !tmo_w && (src_ff == SRC_TARGET || (src_ff == SRC_MOTOR && cl_ff));
      stop_w    = !tmo_w && (src_ff == SRC_MOTOR) && st_ff;
      ctrl_w    = enabled_w && closed_w && !stop_w;

      tgt_ext  = ERR_W'(tgt_in_ff);
      lim_s    = $signed({2'b00, cfg_limit_ff});
      neg_lim  = -lim_s;
      over_w   = tgt_ext > lim_s;
      under_w  = tgt_ext < neg_lim;
      tgt_clip = over_w ? lim_s[RPM_W-1:0] : (under_w ? neg_lim[RPM_W-1:0] : tgt_in_ff);
      tgt_w    = ctrl_w ? tgt_clip : '0;
      tgt_neg  = -tgt_w;
      tgt_abs  = tgt_w[RPM_W-1] ? tgt_neg[LIM_W-1:0] : tgt_w[LIM_W-1:0];

      ceil_w   = (cfg_ceil_ff == '0 || cfg_ceil_ff > FRAC_ONE) ? FRAC_ONE : cfg_ceil_ff;
      dcap_w   = (cfg_defcap_ff != '0) ? cfg_defcap_ff : ceil_w;
      mcap_w   = (ccap_ff != '0) ? ccap_ff : dcap_w;
      mcap_lim = (mcap_w > ceil_w) ? ceil_w : mcap_w;
      if (tmo_w) begin
         cap_w = '0;
      end else if (src_ff == SRC_TARGET) begin
         cap_w = FRAC_ONE;
      end else if (src_ff == SRC_MOTOR) begin
         cap_w = mcap_lim;
      end else begin
         cap_w = '0;
      end
      alpha_w = (cfg_alpha_ff > FRAC_ONE) ? FRAC_ONE : cfg_alpha_ff;

      div_ge  = rem_ff >= {1'b0, cfg_limit_ff};
      div_rem = div_ge ? (rem_ff - {1'b0, cfg_limit_ff}) : rem_ff;

      if (state_ff == ST_MUL_LAG) begin
         mul_a = diff_ff;
         mul_b = $signed({1'b0, alpha_w});
      end else begin
         mul_a = MUL_A_W'(tgt_ff);
         mul_b = $signed({1'b0, cap_ff});
      end
      mul_p = mul_a * mul_b;

      rnd_w = rnd16(prod_ff);
      m_sum = STEP_W'(m_ff) + rnd_w;
      if (m_sum > STEP_W'(RPM_MAX)) begin
         m_clip = RPM_MAX;
      end else if (m_sum < STEP_W'(RPM_MIN)) begin
         m_clip = RPM_MIN;
      end else begin
         m_clip = m_sum[RPM_W-1:0];
      end
      m_neg = -m_clip;
      m_abs = m_clip[RPM_W-1] ? m_neg : m_clip;
      if (m_clip == RPM_MIN) begin
         m_abs = {1'b1, {(RPM_W-1){1'b0}}};
      end
      m_new = (!ctrl_ff && m_abs < {1'b0, cfg_snap_ff}) ? '0 : m_clip;

      rduty_w = (ctrl_ff && cfg_limit_ff != '0) ? quo_ff : '0;
      duty_w  = (rduty_w > cap_ff) ? cap_ff : rduty_w;
      sat_w   = ctrl_ff && (clamped_ff || rduty_w > cap_ff);
      if (tgt_ff > 0) begin
         dir_w = 2'b01;
      end else if (tgt_ff < 0) begin
         dir_w = 2'b11;
      end else begin
         dir_w = 2'b00;
      end
      err_w = ERR_W'(tgt_ff) - ERR_W'(m_new);

      flags_w                 = '0;
      flags_w[FLAG_ENABLED]   = enabled_ff;
      flags_w[FLAG_CONTROL]   = ctrl_ff;
      flags_w[FLAG_CLOSED]    = closed_ff;
      flags_w[FLAG_TIMEOUT]   = tmo_ff;
      flags_w[FLAG_LEGACY]    = !tmo_ff && (src_ff == SRC_LEGACY);
      flags_w[FLAG_SATURATED] = sat_w;
      flags_w[FLAG_ESTOP]     = stop_ff;
      flags_w[FLAG_FAULT]     = 1'b0;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               src_ff    <= src_type'(req_tuser);
               en_ff     <= req_tdata[0];
               cl_ff     <= req_tdata[1];
               st_ff     <= req_tdata[2];
               tgt_in_ff <= $signed(req_tdata[26:3]);
               ccap_ff   <= req_tdata[43:27];
               cto_ff    <= req_tdata[75:44];
               ctime_ff  <= req_tdata[107:76];
               seq_ff    <= req_tdata[139:108];
               now_ff    <= req_tdata[171:140];
               count_ff  <= req_tdata[203:172];
            end
         end
         ST_LIMITS: begin
            lo_ff  <= lo_w;
            hi_ff  <= (cfg_max_to_ff >= lo_w) ? cfg_max_to_ff : lo_w;
            age_ff <= now_ff - ctime_ff;
         end
         ST_CLAMP: begin
            if (to_sel < lo_ff) begin
               to_ff <= lo_ff;
            end else if (to_sel > hi_ff) begin
               to_ff <= hi_ff;
            end else begin
               to_ff <= to_sel;
            end
         end
         ST_EVAL: begin
            tmo_ff     <= tmo_w;
            enabled_ff <= enabled_w;
            closed_ff  <= closed_w;
            stop_ff    <= stop_w;
            ctrl_ff    <= ctrl_w;
            clamped_ff <= ctrl_w && (over_w || under_w);
            tgt_ff     <= tgt_w;
            cap_ff     <= cap_w;
            rem_ff     <= {1'b0, tgt_abs};
            quo_ff     <= '0;
            cnt_ff     <= '0;
         end
         ST_DIV: begin
            rem_ff <= {div_rem[LIM_W-1:0], 1'b0};
            quo_ff <= {quo_ff[CAP_W-2:0], div_ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         ST_MUL_EFF: prod_ff <= mul_p;
         ST_ROUND:   eff_ff  <= rnd_w[RPM_W-1:0];
         ST_DIFF:    diff_ff <= ERR_W'(eff_ff) - ERR_W'(m_ff);
         ST_MUL_LAG: prod_ff <= mul_p;
         ST_DONE: begin
            if (load_rsp) begin
               rsp_tdata_ff <= {3'b000, now_ff, count_ff, seq_ff, flags_w, dir_w, to_ff,
                                cap_ff, duty_w, err_w, m_new, tgt_ff};
               rsp_tuser_ff <= tmo_ff ? SRC_NONE : src_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            m_ff         <= m_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: src/mcrm_checker.sv
// ----------------------------------------------------------------------------
// Motor command response model checker
// Port-level properties of the motor command block, bound to its top level.
// ----------------------------------------------------------------------------
`include "motor_command_response_model_defines.svh"

module mcrm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mcrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mcrm_pkg::SRC_W-1:0]      rsp_tuser
);
   import mcrm_pkg::*;

   logic signed [RPM_W-1:0] target_w, model_w;
   logic signed [ERR_W-1:0] error_w;
   logic [CAP_W-1:0]        duty_w, cap_w;
   logic [DIR_W-1:0]        dir_w;
   logic [FLAG_W-1:0]       flags_w;

   assign target_w = $signed(rsp_tdata[23:0]);
   assign model_w  = $signed(rsp_tdata[47:24]);
   assign error_w  = $signed(rsp_tdata[72:48]);
   assign duty_w   = rsp_tdata[89:73];
   assign cap_w    = rsp_tdata[106:90];
   assign dir_w    = rsp_tdata[140:139];
   assign flags_w  = rsp_tdata[148:141];

   `MCRM_ASSERT_NEXT(busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "tick accepted while the previous one was still at work")
   `MCRM_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result transaction changed")
   `MCRM_ASSERT_SAME(timeout_quiet, clock, reset, rsp_tvalid && flags_w[FLAG_TIMEOUT], (rsp_tuser == SRC_NONE) && (cap_w == '0) && (duty_w == '0), "timed-out tick drives a source, cap or duty")
   `MCRM_ASSERT_SAME(duty_has_dir, clock, reset, rsp_tvalid && (duty_w != '0), (dir_w != 2'b00) && flags_w[FLAG_CONTROL], "nonzero duty without direction or control")
   `MCRM_ASSERT_SAME(error_match, clock, reset, rsp_tvalid, error_w == (ERR_W'(target_w) - ERR_W'(model_w)), "rpm error does not match target minus modelled rpm")

endmodule

bind motor_command_response_model mcrm_checker u_mcrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
